// ===== rtl/dncd_pkg.sv =====
package dncd_pkg;

    localparam int unsigned DAY_W   = 32;
    localparam int unsigned Q400_W  = 15;   // 400-year spans in a 32-bit count
    localparam int unsigned REM_W   = 18;   // day within a 400-year span
    localparam int unsigned YEAR_W  = 24;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned MDAY_W  = 5;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned OUT_W   = 40;   // result fields rounded up to whole bytes

    localparam int unsigned RECIP_SHIFT = 48;

    localparam logic [31:0] DAYS_400Y  = 32'd146097;
    localparam logic [31:0] RECIP_400Y = 32'((64'd1 << RECIP_SHIFT) / 64'd146097);

    localparam logic [17:0] CENT1_START = 18'd36525;
    localparam logic [17:0] CENT2_START = 18'd73049;
    localparam logic [17:0] CENT3_START = 18'd109573;

    localparam logic [15:0] DAYS_4Y     = 16'd1461;
    localparam int unsigned RECIP4_SHIFT = 24;
    localparam logic [15:0] RECIP_4Y    = 16'((32'd1 << RECIP4_SHIFT) / 32'd1461);

    typedef struct packed {
        logic [Q400_W-1:0] q400;
        logic [REM_W-1:0]  rem;
    } t_span;

    // Day of year at which month m+1 starts (m = 0 is January).
    function automatic logic [DOY_W-1:0] month_start(input logic leap, input logic [3:0] m);
        logic [DOY_W-1:0] base;
        logic             adj;
        unique case (m)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd365;
        endcase
        adj = leap && (m >= 4'd2);
        return base + {8'd0, adj};
    endfunction

endpackage

// ===== rtl/dncd_div400.sv =====
module dncd_div400 (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [dncd_pkg::DAY_W-1:0]  i_days,
    output logic                        o_valid,
    input  logic                        i_ready,
    output dncd_pkg::t_span             o_span
);
    import dncd_pkg::*;

    logic [2:0] r_vld;
    logic [2:0] w_en;

    logic [DAY_W-1:0]   r1_days;
    logic [63:0]        r1_prod;
    logic [DAY_W-1:0]   r2_days;
    logic [Q400_W-1:0]  r2_q;
    logic [DAY_W-1:0]   r2_back;
    t_span              r3_span;

    logic [Q400_W-1:0]  n_q2;
    logic [DAY_W-1:0]   n_r3;
    logic               n_fix;

    assign w_en[2] = !r_vld[2] || i_ready;
    assign w_en[1] = !r_vld[1] || w_en[2];
    assign w_en[0] = !r_vld[0] || w_en[1];
    assign o_ready = w_en[0];
    assign o_valid = r_vld[2];
    assign o_span  = r3_span;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    // quotient estimate is exact or one short
    assign n_q2  = r1_prod[RECIP_SHIFT+Q400_W-1:RECIP_SHIFT];
    assign n_r3  = r2_days - r2_back;
    assign n_fix = (n_r3 >= DAYS_400Y);

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_days <= i_days;
            r1_prod <= {32'd0, i_days} * {32'd0, RECIP_400Y};
        end
        if (w_en[1]) begin
            r2_days <= r1_days;
            r2_q    <= n_q2;
            r2_back <= 32'({17'd0, n_q2} * DAYS_400Y);
        end
        if (w_en[2]) begin
            r3_span.q400 <= r2_q + {{(Q400_W-1){1'b0}}, n_fix};
            r3_span.rem  <= REM_W'(n_fix ? (n_r3 - DAYS_400Y) : n_r3);
        end
    end

endmodule

// ===== rtl/day_number_to_civil_date.sv =====
// Day count to civil date, proleptic Gregorian calendar. A 32-bit count of
// days since 1 January of year 0 enters on the slave stream and leaves as year,
// month and day of month on the master stream. Every count is a valid date, so
// there is exactly one result beat per input beat and no error path. The block
// is a nine-stage pipeline that sustains one beat per clock while the master
// stream does not stall. Stage depth is set by the reciprocal multiplier
// that splits off 400-year spans (a 32x32 product, then a 15x18 back-multiply
// and a correcting subtract, one stage each). Each stage carries its own valid
// bit and stalls only when full and blocked downstream, so bubbles collapse and
// a new beat is taken while a finished result waits on the output register.
module day_number_to_civil_date (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // [31:0] day_count
    input  logic [dncd_pkg::DAY_W-1:0]   i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  logic                         i_m_axis_tready,
    // [23:0] year_number, [27:24] month_number, [32:28] day_of_month, [39:33] zero
    output logic [dncd_pkg::OUT_W-1:0]   o_m_axis_tdata
);
    import dncd_pkg::*;

    // stage 1..3: 400-year split
    logic  w_span_vld;
    logic  w_span_rdy;
    t_span w_span;

    dncd_div400 u_div400 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_days  (i_s_axis_tdata),
        .o_valid (w_span_vld),
        .i_ready (w_span_rdy),
        .o_span  (w_span)
    );

    // stages 4..9 in this file
    logic [5:0] r_vld;
    logic [5:0] w_en;

    assign w_en[5] = !r_vld[5] || i_m_axis_tready;
    assign w_en[4] = !r_vld[4] || w_en[5];
    assign w_en[3] = !r_vld[3] || w_en[4];
    assign w_en[2] = !r_vld[2] || w_en[3];
    assign w_en[1] = !r_vld[1] || w_en[2];
    assign w_en[0] = !r_vld[0] || w_en[1];
    assign w_span_rdy = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= w_span_vld;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
            if (w_en[4]) r_vld[4] <= r_vld[3];
            if (w_en[5]) r_vld[5] <= r_vld[4];
        end
    end

    // ---- stage 4: century within the span -------------------------------
    // First century holds 36525 days (leading leap year), the others 36524.
    logic [1:0]        n_c4;
    logic [REM_W-1:0]  n_base4;
    logic [1:0]        r4_c;
    logic [15:0]       r4_x;        // day within the century
    logic [YEAR_W-1:0] r4_y400;

    always_comb begin
        if (w_span.rem >= CENT3_START) begin
            n_c4 = 2'd3;  n_base4 = CENT3_START;
        end else if (w_span.rem >= CENT2_START) begin
            n_c4 = 2'd2;  n_base4 = CENT2_START;
        end else if (w_span.rem >= CENT1_START) begin
            n_c4 = 2'd1;  n_base4 = CENT1_START;
        end else begin
            n_c4 = 2'd0;  n_base4 = '0;
        end
    end

    // ---- stage 5: strip the leading year, estimate 4-year groups --------
    // First year of a century is leap only in the first century.
    logic [15:0]       n_thr5;
    logic              n_ge5;
    logic [15:0]       n_rq5;
    logic [31:0]       n_qprod5;
    logic              r5_ge;
    logic [15:0]       r5_rq;
    logic [4:0]        r5_q;
    logic [1:0]        r5_c;
    logic [DOY_W-1:0]  r5_x;
    logic [YEAR_W-1:0] r5_y400;

    assign n_thr5   = (r4_c == 2'd0) ? 16'd366 : 16'd365;
    assign n_ge5    = (r4_x >= n_thr5);
    assign n_rq5    = n_ge5 ? (r4_x - n_thr5) : 16'd0;
    assign n_qprod5 = {16'd0, n_rq5} * {16'd0, RECIP_4Y};

    // ---- stage 6: correct the group count -------------------------------
    logic [15:0]       n_back6;
    logic [15:0]       n_r6;
    logic              n_fix6;
    logic              r6_ge;
    logic [10:0]       r6_r4;       // day within the 4-year group
    logic [4:0]        r6_q;
    logic [1:0]        r6_c;
    logic [DOY_W-1:0]  r6_x;
    logic [YEAR_W-1:0] r6_y400;

    assign n_back6 = 16'({11'd0, r5_q} * DAYS_4Y);
    assign n_r6    = r5_rq - n_back6;
    assign n_fix6  = (n_r6 >= DAYS_4Y);

    // ---- stage 7: year in the group, year number, leap flag -------------
    logic [1:0]        n_k7;
    logic [10:0]       n_kbase7;
    logic [6:0]        n_yoff7;
    logic [DOY_W-1:0]  r7_doy;
    logic [YEAR_W-1:0] r7_year;
    logic              r7_leap;

    always_comb begin
        if (r6_r4 >= 11'd1095) begin
            n_k7 = 2'd3;  n_kbase7 = 11'd1095;
        end else if (r6_r4 >= 11'd730) begin
            n_k7 = 2'd2;  n_kbase7 = 11'd730;
        end else if (r6_r4 >= 11'd365) begin
            n_k7 = 2'd1;  n_kbase7 = 11'd365;
        end else begin
            n_k7 = 2'd0;  n_kbase7 = 11'd0;
        end
        n_yoff7 = r6_ge ? (7'd1 + {r6_q, 2'b00} + {5'd0, n_k7}) : 7'd0;
    end

    // ---- stage 8: month search ------------------------------------------
    logic [MONTH_W-1:0] n_mon8;
    logic [DOY_W-1:0]   n_start8;
    logic [MONTH_W-1:0] r8_mon;
    logic [DOY_W-1:0]   r8_start;
    logic [DOY_W-1:0]   r8_doy;

    always_comb begin
        n_mon8   = 4'd1;
        n_start8 = '0;
        for (int m = 1; m < 12; m++) begin
            if (r7_doy >= month_start(r7_leap, 4'(m))) begin
                n_mon8   = 4'(m + 1);
                n_start8 = month_start(r7_leap, 4'(m));
            end
        end
    end

    // ---- stage 9: day of month, output register -------------------------
    logic [YEAR_W-1:0]  r8_year;
    logic [DOY_W-1:0]   n_mday9;
    logic [OUT_W-1:0]   r9_data;

    assign n_mday9 = r8_doy - r8_start + 9'd1;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r4_c    <= n_c4;
            r4_x    <= 16'(w_span.rem - n_base4);
            r4_y400 <= YEAR_W'({9'd0, w_span.q400} * 24'd400);
        end
        if (w_en[1]) begin
            r5_ge   <= n_ge5;
            r5_rq   <= n_rq5;
            r5_q    <= n_qprod5[RECIP4_SHIFT+4:RECIP4_SHIFT];
            r5_c    <= r4_c;
            r5_x    <= r4_x[DOY_W-1:0];
            r5_y400 <= r4_y400;
        end
        if (w_en[2]) begin
            r6_ge   <= r5_ge;
            r6_r4   <= 11'(n_fix6 ? (n_r6 - DAYS_4Y) : n_r6);
            r6_q    <= r5_q + {4'd0, n_fix6};
            r6_c    <= r5_c;
            r6_x    <= r5_x;
            r6_y400 <= r5_y400;
        end
        if (w_en[3]) begin
            r7_doy  <= r6_ge ? 9'(r6_r4 - n_kbase7) : r6_x;
            r7_year <= r6_y400 + ({22'd0, r6_c} * 24'd100) + {17'd0, n_yoff7};
            // divisible by 4, and not a century start unless it opens the span
            r7_leap <= (n_yoff7[1:0] == 2'b00) && ((n_yoff7 != 7'd0) || (r6_c == 2'd0));
        end
        if (w_en[4]) begin
            r8_mon   <= n_mon8;
            r8_start <= n_start8;
            r8_doy   <= r7_doy;
            r8_year  <= r7_year;
        end
        if (w_en[5]) begin
            r9_data <= {7'd0, n_mday9[MDAY_W-1:0], r8_mon, r8_year};
        end
    end

    assign o_m_axis_tvalid = r_vld[5];
    assign o_m_axis_tdata  = r9_data;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Stream testbench for day_number_to_civil_date.
// Day counts go in on the slave stream; each accepted beat queues the civil
// date computed by an independent model below. Every result beat on the
// master stream is checked field by field against the oldest queued date.
// The random part runs three times: sender mostly busy and receiver mostly
// stalled, then the reverse, then with no idling at all.
module tb;

    import dncd_pkg::*;

    localparam int unsigned SPAN_400Y   = 146097;
    localparam int unsigned FIRST_CENT  = 36525;   // century 0 starts with a leap year
    localparam int unsigned LATER_CENT  = 36524;
    localparam int unsigned QUAD_DAYS   = 1461;
    localparam int unsigned NORMAL_YEAR = 365;
    localparam int unsigned LEAP_YEAR   = 366;
    localparam int unsigned DRAIN_WAIT  = 20;      // pipeline is nine deep
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PRINT_CAP   = 100;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [MDAY_W-1:0]  mday;
    } t_civil_date;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic [DAY_W-1:0]  s_tdata  = '0;
    logic              s_tready;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    t_civil_date       pending_dates[$];
    int unsigned       mismatch_count = 0;
    int unsigned       cycle_count    = 0;
    int unsigned       send_gap_pct   = 9;
    int unsigned       sink_stall_pct = 84;

    day_number_to_civil_date u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Cumulative days before month idx (0 = January).
    function automatic int unsigned days_before_month(input logic leap, input int unsigned idx);
        int unsigned starts[13];
        starts = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
        return starts[idx] + ((leap && idx >= 2) ? 1 : 0);
    endfunction

    function automatic t_civil_date civil_from_days(input logic [DAY_W-1:0] count);
        int unsigned days;
        int unsigned base;
        int unsigned rem;
        int unsigned r;
        int unsigned quad_base;
        int unsigned quads;
        int unsigned in_quad;
        int unsigned yr;
        int unsigned doy;
        int unsigned mon;
        logic        in_quads;
        logic        leap;
        t_civil_date res;
        days     = count;
        base     = (days / SPAN_400Y) * 400;
        rem      = days % SPAN_400Y;
        in_quads = 1'b1;
        r        = 0;
        yr       = 0;
        doy      = 0;
        if (rem >= FIRST_CENT) begin
            // later century: normal first year, then 4-year groups
            r         = rem - FIRST_CENT;
            quad_base = base + (r / LATER_CENT + 1) * 100;
            r         = r % LATER_CENT;
            if (r >= NORMAL_YEAR) begin
                r = r - NORMAL_YEAR;
            end else begin
                in_quads = 1'b0;
                yr       = quad_base;
                doy      = r;
            end
        end else begin
            quad_base = base;
            if (rem >= LEAP_YEAR) begin
                r = rem - LEAP_YEAR;
            end else begin
                in_quads = 1'b0;
                yr       = base;
                doy      = rem;
            end
        end
        if (in_quads) begin
            quads   = r / QUAD_DAYS;
            in_quad = r % QUAD_DAYS;
            if (in_quad < 3 * NORMAL_YEAR) begin
                yr  = quad_base + 1 + quads * 4 + in_quad / NORMAL_YEAR;
                doy = in_quad % NORMAL_YEAR;
            end else begin
                yr  = quad_base + 4 + quads * 4;
                doy = in_quad - 3 * NORMAL_YEAR;
            end
        end
        leap = (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
        mon  = 1;
        for (int unsigned m = 1; m < 12; m++) begin
            if (doy >= days_before_month(leap, m)) begin
                mon = m + 1;
            end
        end
        res.year  = yr[YEAR_W-1:0];
        res.month = mon[MONTH_W-1:0];
        res.mday  = 5'(doy - days_before_month(leap, mon - 1) + 1);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatch_count < PRINT_CAP) begin
            $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // One day count beat; random gaps before it, then hold until taken.
    task automatic send_day(input logic [DAY_W-1:0] count);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= count;
        @(posedge i_clk);
        while (!s_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Scoreboard: check the result beat first, then queue the accepted input.
    always @(posedge i_clk) begin
        t_civil_date want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_dates.size() == 0) begin
                report_mismatch("unexpected beat, year", m_tdata[23:0], 0);
            end else begin
                want = pending_dates.pop_front();
                if (m_tdata[23:0] != want.year) begin
                    report_mismatch("year", m_tdata[23:0], want.year);
                end
                if (m_tdata[27:24] != want.month) begin
                    report_mismatch("month", m_tdata[27:24], want.month);
                end
                if (m_tdata[32:28] != want.mday) begin
                    report_mismatch("day", m_tdata[32:28], want.mday);
                end
                if (m_tdata[39:33] != '0) begin
                    report_mismatch("pad bits", m_tdata[39:33], 0);
                end
            end
        end
        if (i_rst_n && s_tvalid && s_tready) begin
            pending_dates.push_back(civil_from_days(s_tdata));
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_dates.size());
            $display("** day_number_to_civil_date: FAILED **");
            $finish;
        end
    end

    // Leap days, year ends, century and 400-year span boundaries.
    task automatic test_span_edges();
        logic [DAY_W-1:0] edges[] = '{
            32'd0, 32'd58, 32'd59, 32'd60, 32'd365, 32'd366, 32'd1460, 32'd1461,
            32'd36524, 32'd36525, 32'd36889, 32'd36890, 32'd73048, 32'd73049,
            32'd109572, 32'd109573, 32'd146096, 32'd146097, 32'd730544
        };
        foreach (edges[i]) begin
            send_day(edges[i]);
        end
    endtask

    // Input field extremes and bit patterns.
    task automatic test_field_extremes();
        logic [DAY_W-1:0] vals[] = '{
            32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
            32'hAAAA_AAAA, 32'h5555_5555
        };
        foreach (vals[i]) begin
            send_day(vals[i]);
        end
    endtask

    function automatic logic [DAY_W-1:0] random_day();
        int unsigned offsets[] = '{
            0, 59, 60, 365, 366, 1826, 1827, 36524, 36525, 36889, 36890,
            38350, 38351, 73048, 73049, 109572, 109573, 146095, 146096
        };
        int unsigned sel;
        int unsigned pick;
        sel = $urandom_range(0, 3);
        case (sel)
            0: return $urandom;
            1: return $urandom_range(0, 3 * SPAN_400Y);
            2: begin
                pick = $urandom_range(0, offsets.size() - 1);
                return $urandom_range(0, 29398) * SPAN_400Y + offsets[pick]
                       + $urandom_range(0, 4) - 2;
            end
            default: return $urandom_range(32'hFFF0_0000, 32'hFFFF_FFFF);
        endcase
    endfunction

    task automatic test_random_counts(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_day(random_day());
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender busy, receiver mostly stalled
        send_gap_pct   = 9;
        sink_stall_pct = 84;
        test_span_edges();
        test_field_extremes();
        test_random_counts(150);

        // the other way round
        send_gap_pct   = 84;
        sink_stall_pct = 9;
        test_random_counts(150);

        // full rate both sides
        send_gap_pct   = 0;
        sink_stall_pct = 0;
        test_random_counts(150);
        s_tvalid <= 1'b0;

        while (pending_dates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0 && pending_dates.size() == 0) begin
            $display("** day_number_to_civil_date: PASSED **");
        end else begin
            $display("** day_number_to_civil_date: FAILED **");
        end
        $finish;
    end

endmodule
